// ===== sv/rswe_pkg.sv =====
// Shared types, constants and sequencer states for the running statistics block.
`default_nettype none

package rswe_pkg;

	// Default configuration
	localparam int DEF_MAX_COUNT    = 65536;
	localparam int DEF_SAMPLE_WIDTH = 24;

	// Fit coefficients, Q0.32
	localparam logic [31:0] K0 = 32'd3348772262;
	localparam logic [31:0] K1 = 32'd2661604708;
	localparam logic [31:0] K2 = 32'd241790814;
	localparam logic [31:0] K3 = 32'd2479122403;
	localparam logic [31:0] K4 = 32'd2816974867;

	// Limits
	localparam logic [24:0] Y_LIMIT  = 25'd256 << 16;
	localparam logic [37:0] Z_LIMIT  = 38'd2 << 16;
	localparam logic [22:0] STD_TOP  = 23'h7FFFFF;
	localparam logic [23:0] ETA_TOP  = 24'hFFFFFF;
	localparam logic [31:0] BETA_TOP = 32'hFFFFFFFF;

	// Iteration counts of the shared units
	localparam logic [5:0] DIV_STEPS  = 6'd63;
	localparam logic [5:0] MUL_STEPS  = 6'd25;
	localparam logic [5:0] ROOT_STEPS = 6'd24;

	// Status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_EMPTY    = 2'd1;
	localparam logic [1:0] STAT_MEAN_NEG = 2'd2;
	localparam logic [1:0] STAT_FLAT     = 2'd3;

	typedef struct packed {
		logic signed [23:0] sample;
		logic               start_req;
		logic               report;
	} item_t;

	typedef struct packed {
		logic [16:0]        count;
		logic signed [23:0] minimum;
		logic signed [23:0] maximum;
		logic signed [23:0] mean;
		logic [22:0]        std_dev;
		logic [31:0]        weibull_beta;
		logic [23:0]        weibull_eta;
		logic [1:0]         status;
		logic               dropped;
	} stats_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MEAN,
		ST_MS,
		ST_MM,
		ST_ROOT,
		ST_Y,
		ST_KA,
		ST_KB,
		ST_KC,
		ST_BETA,
		ST_K3,
		ST_K4,
		ST_DZ,
		ST_ETA,
		ST_FIN,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

// ===== sv/running_stats_weibull_estimator.sv =====
// Running mean, spread, extremes and Weibull moment fit over a sample series.
// A request without report is folded into the series as it is taken; the next can follow at once.
// A report request runs a sequencer over a shared restoring divider, shift-add multiplier
// and bit-pair square root; stats_valid rises when the sequence ends, with the input held
// off until the result is taken. Asynchronous active-low reset empties the series and
// idles the sequencer.
`default_nettype none

module running_stats_weibull_estimator
	import rswe_pkg::*;
#(
	parameter int MAX_COUNT    = DEF_MAX_COUNT,
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
	input  wire    clk,
	input  wire    arst_n,
	input  wire    item_valid,
	output logic   item_stall,
	input  item_t  item,
	output logic   stats_valid,
	input  wire    stats_stall,
	output stats_t stats
);

	localparam logic signed [23:0] MIN_RST = 24'((1 << (SAMPLE_WIDTH - 1)) - 1);
	localparam logic signed [23:0] MAX_RST = 24'(-(1 << (SAMPLE_WIDTH - 1)));

	state_t state_q, state_d;

	// Series state; the square sum reaches 2^62 when every sample is the most negative
	logic [16:0]        cnt_q;
	logic signed [39:0] sum_q;
	logic [62:0]        sq_q;
	logic signed [23:0] min_q, max_q;
	logic               ovf_q;

	// Report results and intermediates
	logic signed [23:0] mean_q;
	logic [46:0]        ms_q;
	logic [22:0]        sd_q;
	logic [24:0]        y_q;
	logic [37:0]        z_q;
	logic [32:0]        k3z_q;
	logic [31:0]        beta_q;
	logic [23:0]        eta_q;
	logic [1:0]         status_q;

	// Shared units
	logic [5:0]  step_q;
	logic [62:0] dvd_q;
	logic [37:0] rem_q, dvs_q;
	logic [61:0] mca_q, prod_q;
	logic [24:0] mcb_q;
	logic [46:0] sv_q, sr_q, sb_q;

	// Accumulate one sample
	logic signed [SAMPLE_WIDTH-1:0] x_raw;
	logic signed [23:0]             x;
	logic signed [47:0]             x_sq;
	logic [16:0]                    base_cnt;
	logic signed [39:0]             base_sum;
	logic [62:0]                    base_sq;
	logic signed [23:0]             base_min, base_max;
	logic                           base_ovf, add_ok, accept;

	always_comb begin
		x_raw    = item.sample[SAMPLE_WIDTH-1:0];
		x        = 24'(x_raw);
		x_sq     = x * x;
		base_cnt = item.start_req ? '0 : cnt_q;
		base_sum = item.start_req ? '0 : sum_q;
		base_sq  = item.start_req ? '0 : sq_q;
		base_min = item.start_req ? MIN_RST : min_q;
		base_max = item.start_req ? MAX_RST : max_q;
		base_ovf = item.start_req ? 1'b0 : ovf_q;
		add_ok   = base_cnt < 17'(MAX_COUNT);
		accept   = item_valid && !item_stall;
	end

	// Values taken between unit runs
	logic [39:0] abs_sum;
	logic [23:0] abs_mean;
	logic        mean_pos;
	logic [46:0] var_c;
	logic [22:0] sd_c;
	logic [24:0] y_c;
	logic [36:0] b_c;
	logic [45:0] c_c;
	logic [37:0] z_c;
	logic [31:0] beta_c;
	logic [34:0] pos_c, neg_c, f_c;
	logic [23:0] eta_c;

	always_comb begin
		abs_sum  = sum_q[39] ? 40'(-sum_q) : 40'(sum_q);
		abs_mean = mean_q[23] ? 24'(-mean_q) : 24'(mean_q);
		mean_pos = !mean_q[23] && (mean_q != '0);
		var_c    = (62'(ms_q) > prod_q) ? ms_q - prod_q[46:0] : '0;
		sd_c     = (sr_q > 47'(STD_TOP)) ? STD_TOP : sr_q[22:0];
		y_c      = (dvd_q > 63'(Y_LIMIT)) ? Y_LIMIT : dvd_q[24:0];
		b_c      = 37'(K1) + 37'(prod_q[61:16]);
		c_c      = 46'(K0) + 46'(prod_q[61:16]);
		z_c      = prod_q[53:16];
		beta_c   = (dvd_q > 63'(BETA_TOP)) ? BETA_TOP : dvd_q[31:0];
		pos_c    = (35'd1 << 32) + 35'(k3z_q);
		neg_c    = prod_q[50:16];
		f_c      = pos_c - neg_c;
		eta_c    = (prod_q[61:32] > 30'(ETA_TOP)) ? ETA_TOP : prod_q[55:32];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && item.report) state_d = ST_MEAN;
			ST_MEAN: if (step_q == 6'd1) state_d = ST_MS;
			ST_MS:   if (step_q == 6'd1) state_d = ST_MM;
			ST_MM:   if (step_q == 6'd1) state_d = ST_ROOT;
			ST_ROOT: if (step_q == 6'd1) state_d = ST_Y;
			ST_Y: begin
				if (step_q == '0 && !mean_pos) state_d = ST_OUT;
				else if (step_q == 6'd1) state_d = ST_KA;
			end
			ST_KA:   if (step_q == 6'd1) state_d = ST_KB;
			ST_KB:   if (step_q == 6'd1) state_d = ST_KC;
			ST_KC:   if (step_q == 6'd1) state_d = ST_BETA;
			ST_BETA: if (step_q == 6'd1) state_d = ST_K3;
			ST_K3: begin
				if (step_q == '0 && z_q >= Z_LIMIT) state_d = ST_OUT;
				else if (step_q == 6'd1) state_d = ST_K4;
			end
			ST_K4:   if (step_q == 6'd1) state_d = ST_DZ;
			ST_DZ:   if (step_q == 6'd1) state_d = ST_ETA;
			ST_ETA: begin
				if (step_q == '0 && pos_c <= neg_c) state_d = ST_OUT;
				else if (step_q == 6'd1) state_d = ST_FIN;
			end
			ST_FIN:  state_d = ST_OUT;
			ST_OUT:  if (!stats_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake outputs
	always_comb begin
		item_stall  = (state_q != ST_IDLE);
		stats_valid = (state_q == ST_OUT);
	end

	always_comb begin
		stats.count        = cnt_q;
		stats.minimum      = min_q;
		stats.maximum      = max_q;
		stats.mean         = mean_q;
		stats.std_dev      = sd_q;
		stats.weibull_beta = beta_q;
		stats.weibull_eta  = eta_q;
		stats.status       = status_q;
		stats.dropped      = ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			cnt_q   <= '0;
			sum_q   <= '0;
			sq_q    <= '0;
			min_q   <= MIN_RST;
			max_q   <= MAX_RST;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			// Series update
			if (accept) begin
				cnt_q <= add_ok ? base_cnt + 17'd1 : base_cnt;
				sum_q <= add_ok ? base_sum + 40'(x) : base_sum;
				sq_q  <= add_ok ? base_sq + 63'(unsigned'(x_sq)) : base_sq;
				min_q <= (add_ok && x < base_min) ? x : base_min;
				max_q <= (add_ok && x > base_max) ? x : base_max;
				ovf_q <= base_ovf || !add_ok;
			end
			// Step counter: load at the first cycle of a unit run, then count down
			if (step_q != '0) begin
				step_q <= step_q - 6'd1;
			end else if (state_d == state_q) begin
				unique case (state_q)
					ST_MEAN, ST_MS, ST_Y, ST_BETA:                  step_q <= DIV_STEPS;
					ST_MM, ST_KA, ST_KB, ST_KC, ST_K3, ST_K4, ST_DZ,
					ST_ETA:                                         step_q <= MUL_STEPS;
					ST_ROOT:                                        step_q <= ROOT_STEPS;
					default:                                        step_q <= '0;
				endcase
			end
		end
	end

	// Datapath: operand loads, captures and unit steps
	logic [38:0] trial;
	logic        fits;
	logic [46:0] root_try;

	always_comb begin
		trial    = {rem_q, dvd_q[62]};
		fits     = trial >= {1'b0, dvs_q};
		root_try = sr_q + sb_q;
	end

	always_ff @(posedge clk) begin
		if (accept && item.report) begin
			beta_q   <= '0;
			eta_q    <= '0;
			status_q <= STAT_OK;
		end
		if (step_q != '0) begin
			// One step of whichever unit the state owns
			priority case (state_q)
				ST_MEAN, ST_MS, ST_Y, ST_BETA: begin
					rem_q <= fits ? 38'(trial - {1'b0, dvs_q}) : trial[37:0];
					dvd_q <= {dvd_q[61:0], fits};
				end
				ST_ROOT: begin
					if (sv_q >= root_try) begin
						sv_q <= sv_q - root_try;
						sr_q <= (sr_q >> 1) + sb_q;
					end else begin
						sr_q <= sr_q >> 1;
					end
					sb_q <= sb_q >> 2;
				end
				default: begin
					if (mcb_q[0]) prod_q <= prod_q + mca_q;
					mca_q <= mca_q << 1;
					mcb_q <= mcb_q >> 1;
				end
			endcase
		end else begin
			unique case (state_q)
				ST_MEAN: begin
					dvd_q <= 63'(abs_sum);
					dvs_q <= 38'(cnt_q);
					rem_q <= '0;
				end
				ST_MS: begin
					mean_q <= sum_q[39] ? 24'(-dvd_q[23:0]) : dvd_q[23:0];
					dvd_q  <= sq_q;
					dvs_q  <= 38'(cnt_q);
					rem_q  <= '0;
				end
				ST_MM: begin
					ms_q   <= dvd_q[46:0];
					mca_q  <= 62'(abs_mean);
					mcb_q  <= 25'(abs_mean);
					prod_q <= '0;
				end
				ST_ROOT: begin
					sv_q <= var_c;
					sr_q <= '0;
					sb_q <= 47'd1 << 46;
				end
				ST_Y: begin
					sd_q     <= sd_c;
					status_q <= !mean_pos ? STAT_MEAN_NEG :
					            (sd_c == '0) ? STAT_FLAT : STAT_OK;
					dvd_q    <= 63'({sd_c, 16'd0});
					dvs_q    <= 38'(mean_q[22:0]);
					rem_q    <= '0;
				end
				ST_KA: begin
					y_q    <= y_c;
					mca_q  <= 62'(K2);
					mcb_q  <= y_c;
					prod_q <= '0;
				end
				ST_KB: begin
					mca_q  <= 62'(b_c);
					mcb_q  <= y_q;
					prod_q <= '0;
				end
				ST_KC: begin
					mca_q  <= 62'(c_c[45:16]);
					mcb_q  <= y_q;
					prod_q <= '0;
				end
				ST_BETA: begin
					z_q   <= z_c;
					dvd_q <= 63'd1 << 32;
					dvs_q <= z_c;
					rem_q <= '0;
				end
				ST_K3: begin
					beta_q <= beta_c;
					mca_q  <= 62'(K3);
					mcb_q  <= 25'(z_q[16:0]);
					prod_q <= '0;
				end
				ST_K4: begin
					k3z_q  <= prod_q[48:16];
					mca_q  <= 62'(K4);
					mcb_q  <= 25'(z_q[16:0]);
					prod_q <= '0;
				end
				ST_DZ: begin
					mca_q  <= 62'(prod_q[48:16]);
					mcb_q  <= 25'(z_q[16:0]);
					prod_q <= '0;
				end
				ST_ETA: begin
					mca_q  <= 62'(f_c);
					mcb_q  <= 25'(mean_q[22:0]);
					prod_q <= '0;
				end
				ST_FIN: eta_q <= eta_c;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking bench for the running statistics and Weibull fit block.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
	import rswe_pkg::*;

	typedef struct {
		item_t req;
		bit    hold;   // wait for every outstanding result before sending
		bit    calm;   // no idling on either side while this is sent
	} pend_t;

	logic   clk;
	logic   arst_n;
	logic   item_valid;
	logic   item_stall;
	item_t  item;
	logic   stats_valid;
	logic   stats_stall;
	stats_t stats;

	pend_t  pend_q[$];
	stats_t stats_q[$];
	int     errors;
	int     cycles;
	bit     calm_now;

	// Predictor state
	longint          n_seen;
	longint          sum_seen;
	bit [63:0]       sq_seen;
	longint          lo_seen;
	longint          hi_seen;
	bit              drop_seen;

	running_stats_weibull_estimator u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.stats_valid (stats_valid),
		.stats_stall (stats_stall),
		.stats       (stats)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Floor square root, bit pair at a time
	function automatic bit [63:0] isqrt(bit [63:0] v);
		bit [63:0] r;
		bit [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else
				r = r >> 1;
			b = b >> 2;
		end
		return r;
	endfunction

	task automatic clear_series();
		n_seen = 0;
		sum_seen = 0;
		sq_seen = 0;
		lo_seen = (64'sd1 << (DEF_SAMPLE_WIDTH - 1)) - 1;
		hi_seen = -(64'sd1 << (DEF_SAMPLE_WIDTH - 1));
		drop_seen = 1'b0;
	endtask

	// Fold one request into the series; push the statistics when reported
	task automatic fold_request(item_t r);
		longint    x;
		longint    m;
		bit [63:0] ms, mm, v, sd, beta, eta, mu, y, a, b, c, z, pos, d, neg;
		bit [1:0]  st;
		stats_t    s;
		x = longint'(r.sample);
		if (r.start_req)
			clear_series();
		if (n_seen < DEF_MAX_COUNT) begin
			n_seen++;
			sum_seen += x;
			sq_seen += 64'(x * x);
			if (x < lo_seen) lo_seen = x;
			if (x > hi_seen) hi_seen = x;
		end else
			drop_seen = 1'b1;
		if (!r.report)
			return;
		m = 0; sd = 0; beta = 0; eta = 0; st = STAT_EMPTY;
		if (n_seen != 0) begin
			m = sum_seen / n_seen;
			ms = sq_seen / 64'(n_seen);
			mm = 64'(m * m);
			v = (ms > mm) ? ms - mm : 0;
			sd = isqrt(v);
			if (sd > STD_TOP) sd = STD_TOP;
			if (m <= 0)
				st = STAT_MEAN_NEG;
			else begin
				mu = 64'(m);
				y = (sd << 16) / mu;
				if (y > Y_LIMIT) y = Y_LIMIT;
				a = (64'(K2) * y) >> 16;
				b = 64'(K1) + a;
				c = 64'(K0) + ((b * y) >> 16);
				z = ((c >> 16) * y) >> 16;
				if (z == 0)
					beta = 64'hFFFF_FFFF;
				else begin
					beta = (64'd1 << 32) / z;
					if (beta > 64'hFFFF_FFFF) beta = 64'hFFFF_FFFF;
				end
				if (z < Z_LIMIT) begin
					pos = (64'd1 << 32) + ((64'(K3) * z) >> 16);
					d = (64'(K4) * z) >> 16;
					neg = (d * z) >> 16;
					if (pos > neg) begin
						eta = (mu * (pos - neg)) >> 32;
						if (eta > ETA_TOP) eta = ETA_TOP;
					end
				end
				st = (sd == 0) ? STAT_FLAT : STAT_OK;
			end
		end
		s.count        = n_seen[16:0];
		s.minimum      = lo_seen[23:0];
		s.maximum      = hi_seen[23:0];
		s.mean         = m[23:0];
		s.std_dev      = sd[22:0];
		s.weibull_beta = beta[31:0];
		s.weibull_eta  = eta[23:0];
		s.status       = st;
		s.dropped      = drop_seen;
		stats_q.push_back(s);
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	task automatic queue_req(logic signed [23:0] s, bit st, bit rp, bit hold = 0,
			bit calm = 0);
		pend_t p;
		p.req.sample = s;
		p.req.start_req = st;
		p.req.report = rp;
		p.hold = hold;
		p.calm = calm;
		pend_q.push_back(p);
	endtask

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			clear_series();
		end else begin
			bit sent;
			sent = item_valid && !item_stall;
			if (sent) begin
				fold_request(item);
				void'(pend_q.pop_front());
			end
			if (item_valid && !sent) begin
				// stalled request stays put
			end else if (pend_q.size() == 0) begin
				item_valid <= 1'b0;
			end else if (pend_q[0].hold && (stats_q.size() != 0 || sent)) begin
				item_valid <= 1'b0;
			end else begin
				calm_now = pend_q[0].calm;
				if (!calm_now && $urandom_range(99) < 23)
					item_valid <= 1'b0;
				else begin
					item_valid <= 1'b1;
					item <= pend_q[0].req;
				end
			end
		end
	end

	// Result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stats_stall <= 1'b0;
		else begin
			if (stats_valid && !stats_stall) begin
				if (stats_q.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					stats_t e;
					e = stats_q.pop_front();
					if (stats.count !== e.count) report_mismatch("count", stats.count, e.count);
					if (stats.minimum !== e.minimum)
						report_mismatch("minimum", stats.minimum, e.minimum);
					if (stats.maximum !== e.maximum)
						report_mismatch("maximum", stats.maximum, e.maximum);
					if (stats.mean !== e.mean) report_mismatch("mean", stats.mean, e.mean);
					if (stats.std_dev !== e.std_dev)
						report_mismatch("std_dev", stats.std_dev, e.std_dev);
					if (stats.weibull_beta !== e.weibull_beta)
						report_mismatch("weibull_beta", stats.weibull_beta, e.weibull_beta);
					if (stats.weibull_eta !== e.weibull_eta)
						report_mismatch("weibull_eta", stats.weibull_eta, e.weibull_eta);
					if (stats.status !== e.status)
						report_mismatch("status", stats.status, e.status);
					if (stats.dropped !== e.dropped)
						report_mismatch("dropped", stats.dropped, e.dropped);
				end
			end
			stats_stall <= !calm_now && ($urandom_range(99) < 23);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int i, len, kind;
		longint base, span;
		arst_n = 1'b0;

		// Directed: extremes, flat series, negative mean, large ratio
		queue_req(24'sh7FFFFF, 1, 1);
		queue_req(-24'sd8388608, 0, 1);
		queue_req(24'sd0, 1, 1);
		queue_req(24'sd4096, 1, 0);
		queue_req(24'sd4096, 0, 1);
		queue_req(-24'sd4096, 1, 0);
		queue_req(-24'sd8192, 0, 1);
		queue_req(24'sh7FFFFF, 1, 0);
		queue_req(-24'sd8388605, 0, 1);
		queue_req(24'sd4096, 1, 0);
		queue_req(24'sd5000, 0, 0);
		queue_req(24'sd3200, 0, 1, 1);
		queue_req(24'sh7FFFFF, 1, 0);
		queue_req(24'sh7FFFFF, 0, 1);
		queue_req(24'sd1, 1, 1);
		queue_req(24'sd40960, 1, 0);
		queue_req(24'sd2000, 0, 1);

		// Unbroken run with no idling on either side, then a report after a pause
		queue_req(24'sd8192, 1, 0, 0, 1);
		for (i = 0; i < 100; i++)
			queue_req(24'($urandom_range(20000)), 0, i == 99, 0, 1);
		queue_req(24'sd10, 0, 1, 1);

		// Random series, mostly well formed with varied spread
		i = 0;
		while (i < 720) begin
			len = $urandom_range(1, 12);
			kind = $urandom_range(9);
			base = $urandom_range(1, 1 << 22);
			span = longint'($urandom_range(0, 1 << $urandom_range(0, 22)));
			for (int j = 0; j < len; j++) begin
				logic signed [23:0] s;
				case (kind)
					0, 1:    s = 24'($urandom);
					2:       s = 24'(base);
					3:       s = 24'(-base + longint'($urandom_range(0, 32'(2 * span))));
					default: s = 24'(base - span / 2 + longint'($urandom_range(0, 32'(span))));
				endcase
				queue_req(s, j == 0 ? ($urandom_range(9) != 0) : ($urandom_range(30) == 0),
					(j == len - 1) || ($urandom_range(5) == 0), i == 360 && j == 0);
				i++;
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		wait (pend_q.size() == 0);
		@(posedge clk);
		while (item_valid || stats_q.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
sv/rswe_pkg.sv
sv/running_stats_weibull_estimator.sv
sim/tb_top.sv
